// ===== design/bced_pkg.sv =====
// ----------------------------------------------------------------------------
// bced_pkg: button click event detector shared definitions
// Field widths, level and event codes, register indexes and the types that
// carry items between the front, the event queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package bced_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int BUTTON_W    = 3;
   localparam int LEVEL_W     = 2;
   localparam int EVENT_W     = 3;
   localparam int ENABLE_W    = 8;
   localparam int TICK_W      = 10;
   localparam int MS_W        = 16;
   localparam int COUNT_W     = 17;
   localparam int CLICK_W     = 8;
   localparam int PROD_W      = COUNT_W + TICK_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // up to three events per item
   localparam int EVENTS_MAX = 3;
   localparam int EV_CNT_W   = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [LEVEL_W-1:0] LVL_RELEASED = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_PRESSED  = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_UNKNOWN  = 2'd2;

   localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_LONG    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd2;
   localparam logic [EVENT_W-1:0] EV_CLICK   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_DOUBLE  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_MS         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLICK_WINDOW_MS = 2'd3;

   localparam logic [ENABLE_W-1:0] ENABLE_MASK_RST     = '0;
   localparam logic [TICK_W-1:0]   TICK_MS_RST         = 10'd10;
   localparam logic [MS_W-1:0]     LONG_PRESS_MS_RST   = 16'd1000;
   localparam logic [MS_W-1:0]     CLICK_WINDOW_MS_RST = 16'd300;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

   typedef struct packed {
      logic [BUTTON_W-1:0] button;
      logic [LEVEL_W-1:0]  level;
   } req_item_type;

   typedef struct packed {
      logic [BUTTON_W-1:0] button_id;
      logic [EVENT_W-1:0]  event_res;
      logic                last;
   } rsp_item_type;

   // all events caused by one item
   typedef struct packed {
      logic [BUTTON_W-1:0]                  button_id;
      logic [EV_CNT_W-1:0]                  count;
      logic [EVENTS_MAX-1:0][EVENT_W-1:0]   events;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type data;
   } bundle_write_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== design/bced_front.sv =====
// ----------------------------------------------------------------------------
// bced_front: per-button state and event classification
// Holds the configuration registers and the per-button counters, takes one
// item per cycle unless the queue is full, and queues the events it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  bced_pkg::req_item_type                 req_item,
   input  logic                                   csr_we,
   input  logic [bced_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bced_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  bced_pkg::queue_status_type             q_status,
   output bced_pkg::bundle_write_type             q_write
);
   import bced_pkg::*;

   logic [ENABLE_W-1:0] enable_mask_ff;
   logic [TICK_W-1:0]   tick_ms_ff;
   logic [MS_W-1:0]     long_press_ms_ff;
   logic [MS_W-1:0]     click_window_ms_ff;

   logic [COUNT_W-1:0] hold_count_ff   [NUM_BUTTONS];
   logic [CLICK_W-1:0] click_count_ff  [NUM_BUTTONS];
   logic [COUNT_W-1:0] window_count_ff [NUM_BUTTONS];
   logic [LEVEL_W-1:0] prior_level_ff  [NUM_BUTTONS];

   logic [COUNT_W-1:0] hold_in;
   logic [CLICK_W-1:0] click_in;
   logic [COUNT_W-1:0] window_in;
   logic [LEVEL_W-1:0] prior_in;

   logic [BUTTON_W-1:0] btn;
   logic                btn_ok;
   logic                accept;
   logic [COUNT_W-1:0]  hold_cur;
   logic [CLICK_W-1:0]  click_cur;
   logic [COUNT_W-1:0]  window_cur;
   logic [LEVEL_W-1:0]  prior_cur;
   logic [PROD_W-1:0]   hold_prod;
   logic [PROD_W-1:0]   window_prod;
   logic                long_hit;
   logic                window_hit;

   logic [EVENTS_MAX-1:0][EVENT_W-1:0] ev_list;
   logic [EV_CNT_W-1:0]                ev_cnt;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;
   assign btn    = req_item.button;
   assign btn_ok = (32'(btn) < NUM_BUTTONS) && enable_mask_ff[btn];

   assign hold_cur   = hold_count_ff[btn];
   assign click_cur  = click_count_ff[btn];
   assign window_cur = window_count_ff[btn];
   assign prior_cur  = prior_level_ff[btn];

   assign hold_prod   = PROD_W'(hold_cur) * PROD_W'(tick_ms_ff);
   assign window_prod = PROD_W'(window_cur) * PROD_W'(tick_ms_ff);
   assign long_hit    = hold_prod > PROD_W'(long_press_ms_ff);
   assign window_hit  = window_prod > PROD_W'(click_window_ms_ff);

   always_comb begin
      hold_in   = hold_cur;
      click_in  = click_cur;
      window_in = window_cur;
      prior_in  = prior_cur;
      ev_list   = '0;
      ev_cnt    = '0;

      if (req_item.level == LVL_PRESSED) begin
         ev_list[ev_cnt] = EV_PRESS;
         ev_cnt          = ev_cnt + 2'd1;
         prior_in        = LVL_PRESSED;
         if (long_hit) begin
            ev_list[ev_cnt] = EV_LONG;
            ev_cnt          = ev_cnt + 2'd1;
         end else if (hold_cur != COUNT_MAX) begin
            hold_in = hold_cur + 1'b1;
         end
      end else if (req_item.level == LVL_RELEASED) begin
         hold_in = '0;
         if (prior_cur == LVL_PRESSED) begin
            ev_list[ev_cnt] = EV_RELEASE;
            ev_cnt          = ev_cnt + 2'd1;
            prior_in        = LVL_RELEASED;
            if (click_cur != CLICK_MAX) begin
               click_in = click_cur + 1'b1;
            end
         end
      end

      // click window judged on the count that includes this item's release
      if (window_hit) begin
         if (click_in == CLICK_W'(1)) begin
            ev_list[ev_cnt] = EV_CLICK;
            ev_cnt          = ev_cnt + 2'd1;
         end else if (click_in == CLICK_W'(2)) begin
            ev_list[ev_cnt] = EV_DOUBLE;
            ev_cnt          = ev_cnt + 2'd1;
         end
         window_in = '0;
         click_in  = '0;
      end

      if (click_in != '0 && window_in != COUNT_MAX) begin
         window_in = window_in + 1'b1;
      end
   end

   assign q_write.valid          = accept && btn_ok && (ev_cnt != '0);
   assign q_write.data.button_id = btn;
   assign q_write.data.count     = ev_cnt;
   assign q_write.data.events    = ev_list;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff     <= ENABLE_MASK_RST;
         tick_ms_ff         <= TICK_MS_RST;
         long_press_ms_ff   <= LONG_PRESS_MS_RST;
         click_window_ms_ff <= CLICK_WINDOW_MS_RST;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            hold_count_ff[i]   <= '0;
            click_count_ff[i]  <= '0;
            window_count_ff[i] <= '0;
            prior_level_ff[i]  <= LVL_UNKNOWN;
         end
      end else begin
         if (accept && btn_ok) begin
            hold_count_ff[btn]   <= hold_in;
            click_count_ff[btn]  <= click_in;
            window_count_ff[btn] <= window_in;
            prior_level_ff[btn]  <= prior_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENABLE_MASK: begin
                  // newly enabled buttons start from a clean, unknown state
                  for (int i = 0; i < NUM_BUTTONS; i++) begin
                     if (csr_wdata[i] && !enable_mask_ff[i]) begin
                        hold_count_ff[i]   <= '0;
                        click_count_ff[i]  <= '0;
                        window_count_ff[i] <= '0;
                        prior_level_ff[i]  <= LVL_UNKNOWN;
                     end
                  end
                  enable_mask_ff <= csr_wdata[ENABLE_W-1:0];
               end
               CSR_TICK_MS:         tick_ms_ff         <= csr_wdata[TICK_W-1:0];
               CSR_LONG_PRESS_MS:   long_press_ms_ff   <= csr_wdata[MS_W-1:0];
               CSR_CLICK_WINDOW_MS: click_window_ms_ff <= csr_wdata[MS_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/bced_queue.sv =====
// ----------------------------------------------------------------------------
// bced_queue: event bundle queue
// Short first-in first-out buffer of event bundles between the front and the
// back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  bced_pkg::bundle_write_type    q_write,
   input  logic                          q_pop,
   output bced_pkg::queue_status_type    q_status,
   output bced_pkg::bundle_type          q_head
);
   import bced_pkg::*;

   bundle_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;

   assign q_status.full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_head         = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_write.valid && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_write.valid && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_write.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_write.valid) begin
         entries_ff[wr_ptr_ff] <= q_write.data;
      end
   end

endmodule

`default_nettype wire

// ===== design/bced_back.sv =====
// ----------------------------------------------------------------------------
// bced_back: event serializer and result register
// Takes the bundle at the head of the queue apart into single events, one per
// cycle while results are popped, and holds the oldest result until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bced_pkg::queue_status_type    q_status,
   input  bced_pkg::bundle_type          q_head,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output bced_pkg::rsp_item_type        rsp_item
);
   import bced_pkg::*;

   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff;
   logic [EV_CNT_W-1:0] idx_ff;

   logic take;
   logic load;
   logic is_last;

   assign take    = !rsp_valid_ff || pop;
   assign load    = take && !q_status.empty;
   assign is_last = (idx_ff == q_head.count - 2'd1);
   assign q_pop   = load && is_last;

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (take) begin
         rsp_valid_ff <= load;
         if (load) begin
            idx_ff <= is_last ? '0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff.button_id <= q_head.button_id;
         rsp_item_ff.event_res <= q_head.events[idx_ff];
         rsp_item_ff.last      <= is_last;
      end
   end

endmodule

`default_nettype wire

// ===== design/button_click_event_detector_core.sv =====
// ----------------------------------------------------------------------------
// Path: the events of a taken item go as one bundle into a queue entry,
//   then one by one into the result register while results are popped.
// Throughput: one item per cycle in while the queue has room and items give
//   at most one event each; events leave one per cycle while popped, and a
//   4-deep bundle queue absorbs the difference.
// Reset: synchronous; registers to defaults, all buttons disabled and unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_event_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  bced_pkg::req_item_type              req_item,
   output logic                                empty,
   input  logic                                pop,
   output bced_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_we,
   input  logic [bced_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bced_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bced_pkg::*;

   bundle_write_type q_write;
   queue_status_type q_status;
   bundle_type       q_head;
   logic             q_pop;

   bced_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_write   (q_write)
   );

   bced_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_write  (q_write),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   bced_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

`ifndef SYNTHESIS
   // events of one item come out without a gap
   a_item_contiguous: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.last) |=> !empty)
      else $error("event stream broken inside an item");

   a_same_button: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.last) |=> (rsp_item.button_id == $past(rsp_item.button_id)))
      else $error("button changed inside an item");

   a_after_press: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.last && rsp_item.event_res == EV_PRESS) |=>
      (rsp_item.event_res == EV_LONG || rsp_item.event_res == EV_CLICK ||
       rsp_item.event_res == EV_DOUBLE))
      else $error("bad event after press");

   a_click_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_item.event_res == EV_CLICK || rsp_item.event_res == EV_DOUBLE))
      |-> rsp_item.last)
      else $error("click judgement not last event of item");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: button click event detector core testbench
// Drives button ticks through the push/full queue port and pops events,
// comparing each against an in-bench per-button predictor or a fixed row's list.
// A short table of directed ticks comes first. Random gesture traffic
// follows under three register settings and three idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import bced_pkg::*;

   localparam logic [LEVEL_W-1:0] LVL_RESERVED = 2'd3;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 40;
   localparam int PLAN_ROWS    = 31;
   localparam int PHASE_ITEMS  = 26;

   typedef struct packed {
      logic                               is_reg;
      logic [CSR_INDEX_W-1:0]             idx;
      logic [CSR_DATA_W-1:0]              data;
      req_item_type                       item;
      logic                               fixed;
      logic [1:0]                         n;
      logic [EVENTS_MAX-1:0][EVENT_W-1:0] ev;
   } plan_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_item_type           req_item  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of registers and per-button state
   logic [ENABLE_W-1:0] m_enable;
   logic [TICK_W-1:0]   m_tick;
   logic [MS_W-1:0]     m_long;
   logic [MS_W-1:0]     m_window;
   logic [COUNT_W-1:0]  m_hold   [NUM_BUTTONS];
   logic [COUNT_W-1:0]  m_wcount [NUM_BUTTONS];
   logic [CLICK_W-1:0]  m_clicks [NUM_BUTTONS];
   logic [LEVEL_W-1:0]  m_prior  [NUM_BUTTONS];

   rsp_item_type step_events[$];
   rsp_item_type expected_events[$];

   plan_row_type plan [PLAN_ROWS];

   int send_idle_pct = 32;
   int recv_idle_pct = 75;
   int mismatches    = 0;
   int items_total   = 0;
   int items_enabled = 0;
   int events_seen   = 0;
   int reg_writes    = 0;

   button_click_event_detector_core DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_button(input int b);
      m_hold[b]   = '0;
      m_wcount[b] = '0;
      m_clicks[b] = '0;
      m_prior[b]  = LVL_UNKNOWN;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE_MASK: begin
            // newly enabled buttons start from scratch
            for (int b = 0; b < NUM_BUTTONS; b++)
               if (data[b] && !m_enable[b]) clear_button(b);
            m_enable = data[ENABLE_W-1:0];
         end
         CSR_TICK_MS:         m_tick   = data[TICK_W-1:0];
         CSR_LONG_PRESS_MS:   m_long   = data[MS_W-1:0];
         CSR_CLICK_WINDOW_MS: m_window = data[MS_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void note_event(input logic [BUTTON_W-1:0] b,
                                      input logic [EVENT_W-1:0] ev);
      rsp_item_type e;
      e.button_id = b;
      e.event_res = ev;
      e.last      = 1'b0;
      step_events.push_back(e);
   endfunction

   // events caused by one tick; leaves them in step_events
   function automatic void classify_tick(input req_item_type it);
      logic [BUTTON_W-1:0] b;
      logic [PROD_W-1:0]   held_ms;
      logic [PROD_W-1:0]   open_ms;
      rsp_item_type        e;
      b = it.button;
      step_events.delete();
      if (!m_enable[b]) return;
      held_ms = PROD_W'(m_hold[b]) * PROD_W'(m_tick);
      if (it.level == LVL_PRESSED) begin
         note_event(b, EV_PRESS);
         m_prior[b] = LVL_PRESSED;
         if (held_ms > PROD_W'(m_long)) note_event(b, EV_LONG);
         else if (m_hold[b] != COUNT_MAX) m_hold[b]++;
      end else if (it.level == LVL_RELEASED) begin
         m_hold[b] = '0;
         if (m_prior[b] == LVL_PRESSED) begin
            note_event(b, EV_RELEASE);
            if (m_clicks[b] != CLICK_MAX) m_clicks[b]++;
            m_prior[b] = LVL_RELEASED;
         end
      end
      // window is judged on every level, on the click count with this tick's release
      open_ms = PROD_W'(m_wcount[b]) * PROD_W'(m_tick);
      if (open_ms > PROD_W'(m_window)) begin
         if (m_clicks[b] == CLICK_W'(1)) note_event(b, EV_CLICK);
         else if (m_clicks[b] == CLICK_W'(2)) note_event(b, EV_DOUBLE);
         m_wcount[b] = '0;
         m_clicks[b] = '0;
      end
      if (m_clicks[b] != '0 && m_wcount[b] != COUNT_MAX) m_wcount[b]++;
      if (step_events.size() != 0) begin
         e = step_events[step_events.size()-1];
         e.last = 1'b1;
         step_events[step_events.size()-1] = e;
      end
   endfunction

   function automatic plan_row_type row_reg(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r        = '0;
      r.is_reg = 1'b1;
      r.idx    = idx;
      r.data   = data;
      return r;
   endfunction

   function automatic plan_row_type row_tick(input logic [BUTTON_W-1:0] b,
                                             input logic [LEVEL_W-1:0] lvl);
      plan_row_type r;
      r             = '0;
      r.item.button = b;
      r.item.level  = lvl;
      return r;
   endfunction

   function automatic plan_row_type row_fixed(input logic [BUTTON_W-1:0] b,
                                              input logic [LEVEL_W-1:0] lvl,
                                              input logic [1:0] n,
                                              input logic [EVENT_W-1:0] e0 = EV_PRESS,
                                              input logic [EVENT_W-1:0] e1 = EV_PRESS,
                                              input logic [EVENT_W-1:0] e2 = EV_PRESS);
      plan_row_type r;
      r       = row_tick(b, lvl);
      r.fixed = 1'b1;
      r.n     = n;
      r.ev    = {e2, e1, e0};
      return r;
   endfunction

   function automatic void flag_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // hands one item to the block; fixed rows supply their own expectation
   task automatic push_tick(input req_item_type it, input logic fixed,
                            input logic [1:0] n_fixed,
                            input logic [EVENTS_MAX-1:0][EVENT_W-1:0] ev_fixed);
      rsp_item_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      items_total++;
      if (m_enable[it.button]) items_enabled++;
      classify_tick(it);
      if (fixed) begin
         for (int i = 0; i < int'(n_fixed); i++) begin
            e.button_id = it.button;
            e.event_res = ev_fixed[i];
            e.last      = (i == int'(n_fixed) - 1);
            expected_events.push_back(e);
         end
      end else begin
         foreach (step_events[i]) expected_events.push_back(step_events[i]);
      end
   endtask

   task automatic send_tick(input logic [BUTTON_W-1:0] b, input logic [LEVEL_W-1:0] lvl);
      req_item_type it;
      it.button = b;
      it.level  = lvl;
      push_tick(it, 1'b0, '0, '0);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      // items with no events may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
      csr_we <= 1'b0;
      reg_writes++;
   endtask

   // mostly press/release gestures with random content, some noise
   task automatic run_phase(input int send_pct, input int recv_pct, input int target);
      int                  start;
      int                  r;
      logic [BUTTON_W-1:0] b;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start         = items_total;
      while (items_total - start < target) begin
         r = $urandom_range(99);
         b = BUTTON_W'($urandom_range(NUM_BUTTONS - 1));
         if (r < 65) begin
            repeat ($urandom_range(6, 1)) send_tick(b, LVL_PRESSED);
            send_tick(b, LVL_RELEASED);
            if ($urandom_range(1) == 1) begin
               repeat ($urandom_range(2, 1)) send_tick(b, LVL_PRESSED);
               send_tick(b, LVL_RELEASED);
            end
            repeat ($urandom_range(5)) send_tick(b, ($urandom_range(1) == 1) ?
                                                    LVL_UNKNOWN : LVL_RESERVED);
         end else if (r < 92) begin
            send_tick(b, LEVEL_W'($urandom_range(3)));
         end else begin
            wait_idle();
         end
      end
   endtask

   // event checker
   initial begin
      rsp_item_type want;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $error("unexpected event: button %0d event %0d last %0d",
                         rsp_item.button_id, rsp_item.event_res, rsp_item.last);
            end else begin
               want = expected_events.pop_front();
               flag_field("button_id", want.button_id, rsp_item.button_id);
               flag_field("event_res", want.event_res, rsp_item.event_res);
               flag_field("last", want.last, rsp_item.last);
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int            k;
      logic [15:0]   tick_pick;
      m_enable = ENABLE_MASK_RST;
      m_tick   = TICK_MS_RST;
      m_long   = LONG_PRESS_MS_RST;
      m_window = CLICK_WINDOW_MS_RST;
      for (int b = 0; b < NUM_BUTTONS; b++) clear_button(b);

      plan = '{
         row_fixed(0, LVL_PRESSED, 0),
         row_reg(CSR_ENABLE_MASK, 16'h00FF),
         row_reg(CSR_TICK_MS, 16'd100),
         row_reg(CSR_LONG_PRESS_MS, 16'd150),
         row_reg(CSR_CLICK_WINDOW_MS, 16'd150),
         row_fixed(7, LVL_RELEASED, 0),
         row_fixed(7, LVL_PRESSED, 1, EV_PRESS),
         row_fixed(7, LVL_PRESSED, 1, EV_PRESS),
         row_fixed(7, LVL_PRESSED, 2, EV_PRESS, EV_LONG),
         row_fixed(7, LVL_RELEASED, 1, EV_RELEASE),
         row_fixed(7, LVL_UNKNOWN, 0),
         row_fixed(7, LVL_RESERVED, 1, EV_CLICK),
         row_fixed(2, LVL_PRESSED, 1, EV_PRESS),
         row_fixed(2, LVL_RELEASED, 1, EV_RELEASE),
         row_fixed(2, LVL_PRESSED, 1, EV_PRESS),
         row_fixed(2, LVL_RELEASED, 2, EV_RELEASE, EV_DOUBLE),
         row_reg(CSR_LONG_PRESS_MS, 16'd0),
         row_tick(5, LVL_PRESSED),
         row_tick(5, LVL_RELEASED),
         row_tick(5, LVL_PRESSED),
         row_tick(5, LVL_PRESSED),
         row_reg(CSR_CLICK_WINDOW_MS, 16'd0),
         row_tick(4, LVL_PRESSED),
         row_tick(4, LVL_RELEASED),
         row_tick(4, LVL_UNKNOWN),
         row_reg(CSR_ENABLE_MASK, 16'h00F0),
         row_fixed(3, LVL_PRESSED, 0),
         row_tick(6, LVL_PRESSED),
         row_reg(CSR_TICK_MS, 16'd0),
         row_tick(6, LVL_PRESSED),
         row_tick(6, LVL_PRESSED)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].data);
         else push_tick(plan[i].item, plan[i].fixed, plan[i].n, plan[i].ev);
      end

      // short windows and holds so long presses and clicks come often
      write_reg(CSR_ENABLE_MASK, 16'h00A5);
      write_reg(CSR_TICK_MS, 16'd1);
      write_reg(CSR_LONG_PRESS_MS, 16'd3);
      write_reg(CSR_CLICK_WINDOW_MS, 16'd4);
      run_phase(32, 75, PHASE_ITEMS);

      write_reg(CSR_ENABLE_MASK, 16'h005A);
      write_reg(CSR_ENABLE_MASK, 16'h00FF);
      write_reg(CSR_TICK_MS, 16'd1000);
      write_reg(CSR_LONG_PRESS_MS, 16'd2500);
      write_reg(CSR_CLICK_WINDOW_MS, 16'd3000);
      run_phase(75, 32, PHASE_ITEMS);

      tick_pick = 16'($urandom_range(200, 1));
      write_reg(CSR_TICK_MS, tick_pick);
      write_reg(CSR_LONG_PRESS_MS, 16'(tick_pick * $urandom_range(4)));
      write_reg(CSR_CLICK_WINDOW_MS, 16'(tick_pick * $urandom_range(5, 1)));
      run_phase(0, 0, PHASE_ITEMS);

      push <= 1'b0;
      for (k = 0; k < 5000 && expected_events.size() != 0; k++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_events.size() != 0) begin
         mismatches++;
         $error("%0d expected events never arrived", expected_events.size());
      end

      $display("Run covered %0d ticks (%0d on enabled buttons), %0d events, %0d register writes",
               items_total, items_enabled, events_seen, reg_writes);
      $display("Directed edge cases, then gestures under three idling mixes and settings");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
